@@ src/kvlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared types and codes for the key/value line tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

    // Scan phases
    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_KEY   = 3'd1;
    localparam logic [2:0] PH_EQ    = 3'd2;
    localparam logic [2:0] PH_BARE  = 3'd3;
    localparam logic [2:0] PH_QUOTE = 3'd4;
    localparam logic [2:0] PH_ESC   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_KEY       = 2'd0;
    localparam logic [1:0] KIND_VALUE     = 2'd1;
    localparam logic [1:0] KIND_FIELD_END = 2'd2;
    localparam logic [1:0] KIND_LINE_END  = 2'd3;

    // Field types
    localparam logic [1:0] FT_NULL   = 2'd0;
    localparam logic [1:0] FT_BARE   = 2'd1;
    localparam logic [1:0] FT_QUOTED = 2'd2;

    // Line status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNTERM   = 2'd1;
    localparam logic [1:0] ST_NO_FIELD = 2'd2;

    // Characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int unsigned MAX_RESULTS = 3;
    localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [1:0]  ftype;
        logic [1:0]  status;
        logic [15:0] total;
        logic        last;
    } t_result;

    // All results caused by one input byte, oldest in slot 0
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] slot;
        logic [1:0]                count;
    } t_bundle;

    function automatic t_result mk_result(input logic [1:0] kind, input logic [7:0] data,
                                          input logic [1:0] ftype, input logic [1:0] status,
                                          input logic [15:0] total);
        t_result r;
        r.kind   = kind;
        r.data   = data;
        r.ftype  = ftype;
        r.status = status;
        r.total  = total;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic is_gap(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

@@ src/kvlt_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvlt_scanner
// Phase tracker and field counter: turns one byte into up to three results.
// ----------------------------------------------------------------------------
module kvlt_scanner #(
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output kvlt_pkg::t_bundle o_bundle
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]            r_phase;
    logic [2:0]            n_phase;
    logic [COUNT_BITS-1:0] r_seen;
    logic [COUNT_BITS-1:0] n_seen;

    logic [2:0]            w_ph1;
    logic                  w_inc1;
    logic                  w_inc2;
    logic [COUNT_BITS-1:0] w_cnt_up;
    logic [COUNT_BITS-1:0] w_cnt1;
    logic [COUNT_BITS-1:0] w_cnt2;
    logic [15:0]           w_tot0;
    logic [15:0]           w_tot1;
    logic [15:0]           w_tot2;

    kvlt_pkg::t_result     w_a0;
    kvlt_pkg::t_result     w_a1;
    logic [1:0]            w_na;
    logic                  w_ef;
    logic [1:0]            w_ef_type;
    logic [1:0]            w_status;
    logic [1:0]            w_n;
    kvlt_pkg::t_bundle     w_bundle;

    // Saturating count as it stands once a field closes in the byte phase
    assign w_cnt_up = (r_seen != CNT_MAX) ? r_seen + 1'b1 : r_seen;
    assign w_cnt1   = w_inc1 ? w_cnt_up : r_seen;
    assign w_cnt2   = (w_inc2 && (w_cnt1 != CNT_MAX)) ? w_cnt1 + 1'b1 : w_cnt1;

    // Clip the running count to the 16-bit result field
    generate
        if (COUNT_BITS > 16) begin : g_clip
            assign w_tot0 = (r_seen > COUNT_BITS'(kvlt_pkg::TOTAL_MAX)) ?
                            kvlt_pkg::TOTAL_MAX : r_seen[15:0];
            assign w_tot1 = (w_cnt_up > COUNT_BITS'(kvlt_pkg::TOTAL_MAX)) ?
                            kvlt_pkg::TOTAL_MAX : w_cnt_up[15:0];
            assign w_tot2 = (w_cnt2 > COUNT_BITS'(kvlt_pkg::TOTAL_MAX)) ?
                            kvlt_pkg::TOTAL_MAX : w_cnt2[15:0];
        end else begin : g_ext
            assign w_tot0 = 16'(r_seen);
            assign w_tot1 = 16'(w_cnt_up);
            assign w_tot2 = 16'(w_cnt2);
        end
    endgenerate

    // Byte handling for the current phase
    always_comb begin
        w_ph1  = r_phase;
        w_inc1 = 1'b0;
        w_na   = 2'd0;
        w_a0   = '0;
        w_a1   = '0;
        unique case (r_phase)
            kvlt_pkg::PH_KEY: begin
                if (i_byte == kvlt_pkg::CH_EQUAL) begin
                    w_ph1 = kvlt_pkg::PH_EQ;
                end else if (i_byte <= kvlt_pkg::CH_SPACE || i_byte == kvlt_pkg::CH_QUOTE) begin
                    w_inc1 = 1'b1;
                    w_na   = 2'd1;
                    w_a0   = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                 kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot1);
                    w_ph1  = kvlt_pkg::PH_SKIP;
                end else begin
                    w_na = 2'd1;
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_KEY, i_byte,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end
            end
            kvlt_pkg::PH_EQ: begin
                if (kvlt_pkg::is_gap(i_byte)) begin
                    w_inc1 = 1'b1;
                    w_na   = 2'd1;
                    w_a0   = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                 kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot1);
                    w_ph1  = kvlt_pkg::PH_SKIP;
                end else if (i_byte == kvlt_pkg::CH_QUOTE) begin
                    w_ph1 = kvlt_pkg::PH_QUOTE;
                end else if (i_byte <= kvlt_pkg::CH_SPACE) begin
                    w_inc1 = 1'b1;
                    w_na   = 2'd1;
                    w_a0   = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                 kvlt_pkg::FT_BARE, kvlt_pkg::ST_OK, w_tot1);
                    w_ph1  = kvlt_pkg::PH_SKIP;
                end else begin
                    w_na  = 2'd1;
                    w_a0  = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, i_byte,
                                                kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                    w_ph1 = kvlt_pkg::PH_BARE;
                end
            end
            kvlt_pkg::PH_BARE: begin
                if (i_byte <= kvlt_pkg::CH_SPACE || i_byte == kvlt_pkg::CH_QUOTE) begin
                    w_inc1 = 1'b1;
                    w_na   = 2'd1;
                    w_a0   = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                 kvlt_pkg::FT_BARE, kvlt_pkg::ST_OK, w_tot1);
                    w_ph1  = kvlt_pkg::PH_SKIP;
                end else begin
                    w_na = 2'd1;
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, i_byte,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end
            end
            kvlt_pkg::PH_QUOTE: begin
                if (i_byte == kvlt_pkg::CH_BSLASH) begin
                    w_ph1 = kvlt_pkg::PH_ESC;
                end else if (i_byte == kvlt_pkg::CH_QUOTE) begin
                    w_inc1 = 1'b1;
                    w_na   = 2'd1;
                    w_a0   = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                 kvlt_pkg::FT_QUOTED, kvlt_pkg::ST_OK, w_tot1);
                    w_ph1  = kvlt_pkg::PH_SKIP;
                end else begin
                    w_na = 2'd1;
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, i_byte,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end
            end
            kvlt_pkg::PH_ESC: begin
                w_ph1 = kvlt_pkg::PH_QUOTE;
                w_na  = 2'd1;
                if (i_byte == kvlt_pkg::CH_N) begin
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, kvlt_pkg::CH_LF,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end else if (i_byte == kvlt_pkg::CH_R) begin
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, kvlt_pkg::CH_CR,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end else if (i_byte == kvlt_pkg::CH_T) begin
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, kvlt_pkg::CH_TAB,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end else if (i_byte == kvlt_pkg::CH_QUOTE || i_byte == kvlt_pkg::CH_BSLASH) begin
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, i_byte,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end else begin
                    // Unknown escape: pass the backslash and the byte
                    w_na = 2'd2;
                    w_a0 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, kvlt_pkg::CH_BSLASH,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                    w_a1 = kvlt_pkg::mk_result(kvlt_pkg::KIND_VALUE, i_byte,
                                               kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                end
            end
            default: begin
                w_ph1 = kvlt_pkg::PH_SKIP;
                if (i_byte > kvlt_pkg::CH_SPACE && i_byte != kvlt_pkg::CH_EQUAL &&
                    i_byte != kvlt_pkg::CH_QUOTE) begin
                    w_na  = 2'd1;
                    w_a0  = kvlt_pkg::mk_result(kvlt_pkg::KIND_KEY, i_byte,
                                                kvlt_pkg::FT_NULL, kvlt_pkg::ST_OK, w_tot0);
                    w_ph1 = kvlt_pkg::PH_KEY;
                end
            end
        endcase
    end

    // Line-end handling: close an open field, then report the line
    always_comb begin
        w_ef      = 1'b0;
        w_ef_type = kvlt_pkg::FT_NULL;
        w_status  = kvlt_pkg::ST_OK;
        if (i_last) begin
            if (w_ph1 == kvlt_pkg::PH_KEY || w_ph1 == kvlt_pkg::PH_EQ) begin
                w_ef = 1'b1;
            end else if (w_ph1 == kvlt_pkg::PH_BARE) begin
                w_ef      = 1'b1;
                w_ef_type = kvlt_pkg::FT_BARE;
            end
            // A field closed here always leaves a nonzero count
            if (w_ph1 == kvlt_pkg::PH_QUOTE || w_ph1 == kvlt_pkg::PH_ESC) begin
                w_status = kvlt_pkg::ST_UNTERM;
            end else if ((w_cnt1 == '0) && !w_ef) begin
                w_status = kvlt_pkg::ST_NO_FIELD;
            end
        end
    end

    assign w_inc2 = w_ef;

    // Pack results in order and flag the final one
    always_comb begin
        w_bundle = '0;
        w_n      = 2'd0;
        if (w_na != 2'd0) begin
            w_bundle.slot[w_n] = w_a0;
            w_n                = w_n + 2'd1;
        end
        if (w_na == 2'd2) begin
            w_bundle.slot[w_n] = w_a1;
            w_n                = w_n + 2'd1;
        end
        if (w_ef) begin
            w_bundle.slot[w_n] = kvlt_pkg::mk_result(kvlt_pkg::KIND_FIELD_END, 8'h00,
                                                     w_ef_type, kvlt_pkg::ST_OK, w_tot2);
            w_n                = w_n + 2'd1;
        end
        if (i_last) begin
            w_bundle.slot[w_n] = kvlt_pkg::mk_result(kvlt_pkg::KIND_LINE_END, 8'h00,
                                                     kvlt_pkg::FT_NULL, w_status, w_tot2);
            w_n                = w_n + 2'd1;
        end
        if (w_n != 2'd0) begin
            w_bundle.slot[w_n - 2'd1].last = 1'b1;
        end
        w_bundle.count = w_n;
    end

    assign n_phase = i_last ? kvlt_pkg::PH_SKIP : w_ph1;
    assign n_seen  = i_last ? '0 : w_cnt2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kvlt_pkg::PH_SKIP;
            r_seen  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
        end
    end

    assign o_bundle = w_bundle;

endmodule

@@ src/kvlt_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvlt_out_buf
// Result register: holds one byte's results and sends them one beat each.
// ----------------------------------------------------------------------------
module kvlt_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kvlt_pkg::t_bundle i_bundle,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output kvlt_pkg::t_result o_head
);

    logic [1:0]                                  r_rem;
    kvlt_pkg::t_result [kvlt_pkg::MAX_RESULTS-1:0] r_slot;
    logic                                        w_take;

    assign o_valid = (r_rem != 2'd0);
    assign w_take  = o_valid && i_ready;
    assign o_free  = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_ready);
    assign o_head  = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
        end else if (i_load) begin
            r_rem <= i_bundle.count;
        end else if (w_take) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    // Payload: load whole, or advance to the next result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end else if (w_take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

@@ src/key_value_line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Streaming scanner for key=value log lines, one byte per beat.
// ----------------------------------------------------------------------------
// Feed one line byte per input beat, tlast on the final byte. Each byte
// yields zero to three result beats (key byte, value byte, field end, line
// end); tlast on the output marks the final result of that input byte.
// The block takes one byte per cycle as long as each byte yields at most one
// result and the output is ready; a byte that yields several results holds
// the single output port until all are taken, and the input stalls behind
// it. A byte passes the input register and then the result register before
// its first result is presented; while the result register is busy, the
// byte waits in the input register. Value bytes of a quoted value stream
// before the closing quote is seen: drop the line when the line-end status
// is not ok.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tlast,   // line_last
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] field_type,
                                        // [11:10] line_status, [27:12] field_total,
                                        // [31:28] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    logic              w_s_accept;
    logic              w_free;
    logic              w_adv;
    kvlt_pkg::t_bundle w_bundle;
    kvlt_pkg::t_result w_head;

    // The input register advances whenever the result register can take the
    // whole bundle of results for the byte it holds.
    assign w_adv         = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_free;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the byte until it is scanned
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    kvlt_scanner #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_bundle (w_bundle)
    );

    kvlt_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_bundle (w_bundle),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (w_free),
        .o_head   (w_head)
    );

    assign m_axis_tdata = {4'b0000, w_head.total, w_head.status, w_head.ftype, w_head.data};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    // A line end is always the final result of its byte
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == kvlt_pkg::KIND_LINE_END) |-> m_axis_tlast)
        else $error("line end beat without tlast");

    // A field end counts itself, so its total is never zero
    a_field_end_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == kvlt_pkg::KIND_FIELD_END) |->
        (m_axis_tdata[27:12] != 16'h0000))
        else $error("field end with zero field total");

    // A byte blocked by the result register stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_free) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_last)))
        else $error("input byte lost while result register busy");

    // Only a line end carries a status
    a_status_only_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != kvlt_pkg::KIND_LINE_END) |->
        (m_axis_tdata[11:10] == kvlt_pkg::ST_OK))
        else $error("status set on a non line end beat");

endmodule
